/* hdl/rlbd_pkg.sv */
package rlbd_pkg;

   localparam int OUT_COUNT_WIDTH = 24;
   localparam int LIMIT_WIDTH = 24;
   localparam int SUM_WIDTH =
      ((OUT_COUNT_WIDTH > LIMIT_WIDTH) ? OUT_COUNT_WIDTH : LIMIT_WIDTH) + 1;
   localparam logic [SUM_WIDTH-1:0] COUNT_CAP =
      SUM_WIDTH'((64'd1 << OUT_COUNT_WIDTH) - 64'd1);
   localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(65536);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] KIND_LIT   = 2'd0;
   localparam logic [1:0] KIND_RUN   = 2'd1;
   localparam logic [1:0] KIND_TRUNC = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_TRUNC = 2'd1;
   localparam logic [1:0] STATUS_OVER  = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [7:0] count;
      logic       last;
      logic       trunc;
   } cmd_type;

endpackage

/* hdl/run_length_byte_decoder_core.sv */
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_in_byte, req_last
// rsp       out        rsp_valid/rsp_stall  rsp_out_byte, rsp_repeat_res, rsp_done_res, rsp_status
// csr       in         csr_wr_en            csr_wr_data (output limit)
//
// One request per cycle sustained while req_stall is low; a result passes through
// front classify, the queue, then the back limit check into the output register.
// Synchronous active-high reset; output limit resets to 65536.
// The two-entry queue fills when rsp is stalled, then req_stall rises.
module run_length_byte_decoder_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_in_byte,
   input  logic                             req_last,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_out_byte,
   output logic [7:0]                       rsp_repeat_res,
   output logic                             rsp_done_res,
   output logic [1:0]                       rsp_status,
   input  logic                             csr_wr_en,
   input  logic [rlbd_pkg::LIMIT_WIDTH-1:0] csr_wr_data
);
   import rlbd_pkg::*;

   logic [LIMIT_WIDTH-1:0] limit_ff;
   logic                   push, queue_full, pop, not_empty;
   cmd_type                push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   rlbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_last    (req_last),
      .push        (push),
      .push_cmd    (push_cmd),
      .queue_full  (queue_full)
   );

   rlbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (not_empty),
      .pop_cmd   (pop_cmd)
   );

   rlbd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .output_limit   (limit_ff),
      .cmd_valid      (not_empty),
      .cmd            (pop_cmd),
      .cmd_pop        (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_repeat_res (rsp_repeat_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status)
   );

endmodule

/* hdl/rlbd_front.sv */
module rlbd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_last,
   output logic             push,
   output rlbd_pkg::cmd_type push_cmd,
   input  logic             queue_full
);
   import rlbd_pkg::*;

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_LITERAL = 2'd1;
   localparam logic [1:0] PH_RUNVAL  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] lit_left_ff, lit_left_in;
   logic [7:0] run_len_ff, run_len_in;
   logic       accept;
   logic [7:0] lit_dec;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign lit_dec   = lit_left_ff - 8'd1;

   always_comb begin
      phase_in    = phase_ff;
      lit_left_in = lit_left_ff;
      run_len_in  = run_len_ff;
      push        = 1'b0;
      push_cmd    = '{kind: KIND_TRUNC, value: req_in_byte, count: 8'd1,
                      last: req_last, trunc: 1'b0};
      if (accept) begin
         case (phase_ff)
            PH_LITERAL: begin
               push           = 1'b1;
               push_cmd.kind  = KIND_LIT;
               push_cmd.trunc = req_last && (lit_dec != 8'd0);
               lit_left_in    = lit_dec;
               if (lit_dec == 8'd0) begin
                  phase_in = PH_HEADER;
               end
            end
            PH_RUNVAL: begin
               push           = 1'b1;
               push_cmd.kind  = KIND_RUN;
               push_cmd.count = run_len_ff + 8'd1;
               phase_in       = PH_HEADER;
            end
            default: begin
               if (req_in_byte[7]) begin
                  lit_left_in = ~req_in_byte + 8'd1;
                  phase_in    = PH_LITERAL;
               end else begin
                  run_len_in = req_in_byte;
                  phase_in   = PH_RUNVAL;
               end
               push = req_last;
            end
         endcase
         if (req_last) begin
            phase_in    = PH_HEADER;
            lit_left_in = 8'd0;
            run_len_in  = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEADER;
         lit_left_ff <= 8'd0;
         run_len_ff  <= 8'd0;
      end else begin
         phase_ff    <= phase_in;
         lit_left_ff <= lit_left_in;
         run_len_ff  <= run_len_in;
      end
   end

endmodule

/* hdl/rlbd_queue.sv */
module rlbd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rlbd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output rlbd_pkg::cmd_type pop_cmd
);
   import rlbd_pkg::*;

   cmd_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_WIDTH:0]   fill_ff, fill_in;
   logic                       do_push, do_pop;

   assign full      = (fill_ff == (QUEUE_PTR_WIDTH+1)'(QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* hdl/rlbd_back.sv */
module rlbd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [rlbd_pkg::LIMIT_WIDTH-1:0]   output_limit,
   input  logic                               cmd_valid,
   input  rlbd_pkg::cmd_type                  cmd,
   output logic                               cmd_pop,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [7:0]                         rsp_out_byte,
   output logic [7:0]                         rsp_repeat_res,
   output logic                               rsp_done_res,
   output logic [1:0]                         rsp_status
);
   import rlbd_pkg::*;

   logic [OUT_COUNT_WIDTH-1:0] produced_ff, produced_in;
   logic                       error_ff, error_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [7:0]                 rep_ff, rep_in;
   logic                       done_ff, done_in;
   logic [1:0]                 status_ff, status_in;
   logic [SUM_WIDTH-1:0]       limit_eff;
   logic [SUM_WIDTH-1:0]       sum;
   logic                       take;

   assign limit_eff = (SUM_WIDTH'(output_limit) < COUNT_CAP) ? SUM_WIDTH'(output_limit)
                      : COUNT_CAP;
   assign sum       = SUM_WIDTH'(produced_ff) + SUM_WIDTH'(cmd.count);
   assign take      = cmd_valid && (!valid_ff || !rsp_stall);
   assign cmd_pop   = take;

   always_comb begin
      produced_in = produced_ff;
      error_in    = error_ff;
      valid_in    = valid_ff && rsp_stall;
      byte_in     = byte_ff;
      rep_in      = rep_ff;
      done_in     = done_ff;
      status_in   = status_ff;
      if (take) begin
         if (!error_ff) begin
            valid_in = 1'b1;
            if (cmd.kind == KIND_TRUNC) begin
               byte_in   = 8'd0;
               rep_in    = 8'd0;
               done_in   = 1'b1;
               status_in = STATUS_TRUNC;
            end else if (sum > limit_eff) begin
               byte_in   = 8'd0;
               rep_in    = 8'd0;
               done_in   = 1'b1;
               status_in = STATUS_OVER;
               error_in  = 1'b1;
            end else begin
               produced_in = sum[OUT_COUNT_WIDTH-1:0];
               byte_in     = cmd.value;
               rep_in      = cmd.count;
               done_in     = cmd.last;
               status_in   = cmd.trunc ? STATUS_TRUNC : STATUS_OK;
            end
         end
         if (cmd.last) begin
            produced_in = '0;
            error_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         produced_ff <= '0;
         error_ff    <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         produced_ff <= produced_in;
         error_ff    <= error_in;
         valid_ff    <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      rep_ff    <= rep_in;
      done_ff   <= done_in;
      status_ff <= status_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_repeat_res = rep_ff;
   assign rsp_done_res   = done_ff;
   assign rsp_status     = status_ff;

endmodule
